// File: rtl/core/flol_pkg.sv
package flol_pkg;

	// command codes
	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_LOCATE = 2'd2;
	localparam logic [1:0] CMD_READ   = 2'd3;

	// status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [1:0] STATUS_FULL      = 2'd2;
	localparam logic [1:0] STATUS_BEYOND    = 2'd3;

	// fixed field widths
	localparam int VALUE_W = 32;
	localparam int POS_W   = 4;
	localparam int CNT_W   = 16;

	// one result transaction
	typedef struct packed {
		logic [1:0]         status;
		logic [POS_W-1:0]   position;
		logic [VALUE_W-1:0] value;
		logic [CNT_W-1:0]   count;
	} result_t;

endpackage

// File: rtl/core/flol_mem.sv
module flol_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 48
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/flol_ctrl.sv
module flol_ctrl #(
	parameter int DEPTH      = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [1:0]                          cmd,
	input  logic [flol_pkg::VALUE_W-1:0]        value,
	input  logic [flol_pkg::POS_W-1:0]          position,
	output logic                                res_valid,
	input  logic                                res_ready,
	output flol_pkg::result_t                   res,
	output logic                                mem_re,
	output logic [$clog2(DEPTH)-1:0]            mem_raddr,
	input  logic [flol_pkg::VALUE_W+COUNT_BITS-1:0] mem_rdata,
	output logic                                mem_we,
	output logic [$clog2(DEPTH)-1:0]            mem_waddr,
	output logic [flol_pkg::VALUE_W+COUNT_BITS-1:0] mem_wdata
);

	localparam int AW = $clog2(DEPTH);
	localparam int UW = $clog2(DEPTH + 1);
	localparam int VW = flol_pkg::VALUE_W;
	localparam int EW = VW + COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_PLACE = 3'd3;
	localparam logic [2:0] S_RDOUT = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]            state_q, state_d;
	logic [UW-1:0]         used_q, used_d;
	logic [AW-1:0]         addr_q, addr_d;
	logic [VW-1:0]         key_q, key_d;
	logic [VW-1:0]         val_q, val_d;
	logic [COUNT_BITS-1:0] cnt_q, cnt_d;
	flol_pkg::result_t     res_q, res_d;

	logic [VW-1:0]         rd_value;
	logic [COUNT_BITS-1:0] rd_count;
	logic [COUNT_BITS-1:0] rd_count_inc;
	logic [AW-1:0]         last_addr;
	logic [AW-1:0]         addr_up;
	logic [AW-1:0]         addr_dn;

	function automatic logic [flol_pkg::CNT_W-1:0] cnt16(input logic [COUNT_BITS-1:0] c);
		logic [31:0] w;
		w = 32'(c);
		return w[flol_pkg::CNT_W-1:0];
	endfunction

	// split the read entry and bump its count with saturation
	assign rd_value     = mem_rdata[EW-1:COUNT_BITS];
	assign rd_count     = mem_rdata[COUNT_BITS-1:0];
	assign rd_count_inc = (rd_count == COUNT_MAX) ? COUNT_MAX : rd_count + COUNT_BITS'(1);
	assign last_addr    = AW'(used_q - UW'(1));
	assign addr_up      = addr_q + AW'(1);
	assign addr_dn      = addr_q - AW'(1);

	assign req_ready = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	// sequence clear, append, locate (scan then shift) and read
	always_comb begin
		state_d   = state_q;
		used_d    = used_q;
		addr_d    = addr_q;
		key_d     = key_q;
		val_d     = val_q;
		cnt_d     = cnt_q;
		res_d     = res_q;
		mem_re    = 1'b0;
		mem_raddr = addr_q;
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = {val_q, cnt_q};
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					key_d   = value;
					state_d = S_DONE;
					case (cmd)
						flol_pkg::CMD_CLEAR: begin
							used_d = '0;
							res_d  = '{flol_pkg::STATUS_OK, '0, '0, '0};
						end
						flol_pkg::CMD_APPEND: begin
							if (32'(used_q) >= DEPTH) begin
								res_d = '{flol_pkg::STATUS_FULL, '0, '0, '0};
							end else begin
								mem_we    = 1'b1;
								mem_waddr = AW'(used_q);
								mem_wdata = {value, {COUNT_BITS{1'b0}}};
								used_d    = used_q + UW'(1);
								res_d     = '{flol_pkg::STATUS_OK,
									flol_pkg::POS_W'(used_q), value, '0};
							end
						end
						flol_pkg::CMD_LOCATE: begin
							if (used_q == '0) begin
								res_d = '{flol_pkg::STATUS_NOT_FOUND, '0, '0, '0};
							end else begin
								mem_re    = 1'b1;
								mem_raddr = '0;
								addr_d    = '0;
								state_d   = S_SCAN;
							end
						end
						flol_pkg::CMD_READ: begin
							if (32'(position) >= 32'(used_q)) begin
								res_d = '{flol_pkg::STATUS_BEYOND, '0, '0, '0};
							end else begin
								mem_re    = 1'b1;
								mem_raddr = AW'(position);
								addr_d    = AW'(position);
								state_d   = S_RDOUT;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (rd_value == key_q) begin
					val_d = rd_value;
					cnt_d = rd_count_inc;
					if (addr_q == '0) begin
						mem_we    = 1'b1;
						mem_waddr = '0;
						mem_wdata = {rd_value, rd_count_inc};
						res_d     = '{flol_pkg::STATUS_OK, '0, rd_value, cnt16(rd_count_inc)};
						state_d   = S_DONE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = addr_dn;
						addr_d    = addr_dn;
						state_d   = S_SHIFT;
					end
				end else if (addr_q == last_addr) begin
					res_d   = '{flol_pkg::STATUS_NOT_FOUND, '0, '0, '0};
					state_d = S_DONE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = addr_up;
					addr_d    = addr_up;
				end
			end
			S_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = addr_up;
				if (rd_count <= cnt_q) begin
					// move this entry one place back
					mem_wdata = mem_rdata;
					if (addr_q == '0) begin
						state_d = S_PLACE;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = addr_dn;
						addr_d    = addr_dn;
					end
				end else begin
					// drop the located entry in behind this one
					mem_wdata = {val_q, cnt_q};
					res_d     = '{flol_pkg::STATUS_OK, flol_pkg::POS_W'(addr_up),
						val_q, cnt16(cnt_q)};
					state_d   = S_DONE;
				end
			end
			S_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
				res_d     = '{flol_pkg::STATUS_OK, '0, val_q, cnt16(cnt_q)};
				state_d   = S_DONE;
			end
			S_RDOUT: begin
				res_d   = '{flol_pkg::STATUS_OK, flol_pkg::POS_W'(addr_q),
					rd_value, cnt16(rd_count)};
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
		end else begin
			state_q <= state_d;
			used_q  <= used_d;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		key_q  <= key_d;
		val_q  <= val_d;
		cnt_q  <= cnt_d;
		res_q  <= res_d;
	end

	// reads stay inside the filled part of the table
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (32'(mem_raddr) < 32'(used_q)))
		else $error("read beyond filled entries");

	// fill count never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n)
		32'(used_q) <= DEPTH)
		else $error("fill count overflow");

	// fill count changes only when a transaction is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(used_q))
		else $error("fill count changed mid-operation");

endmodule

// File: rtl/core/frequency_ordered_lookup_table.sv
// Clear, append, a locate on an empty table and an out-of-range read finish on acceptance;
// a read adds one table read; a locate scans from the head until it hits or passes the last
// entry, then shifts entries ahead of the hit back until the hit's new slot is reached.
// Scan and shift move one entry per cycle through the single registered table memory.
// One transaction is handled at a time; the next is taken the cycle after the result enters
// the output register. Reset empties the table.
module frequency_ordered_lookup_table #(
	parameter int DEPTH      = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_ready,
	input  logic [1:0]                         cmd,
	input  logic signed [flol_pkg::VALUE_W-1:0] value,
	input  logic [flol_pkg::POS_W-1:0]         position,
	output logic                               rsp_valid,
	input  logic                               rsp_ready,
	output logic [1:0]                         status,
	output logic [flol_pkg::POS_W-1:0]         entry_position,
	output logic signed [flol_pkg::VALUE_W-1:0] entry_value,
	output logic [flol_pkg::CNT_W-1:0]         entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int EW = flol_pkg::VALUE_W + COUNT_BITS;

	logic              res_valid;
	logic              res_ready;
	flol_pkg::result_t res;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [EW-1:0]     mem_rdata;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [EW-1:0]     mem_wdata;
	logic              rsp_valid_q;
	flol_pkg::result_t rsp_q;

	flol_ctrl #(
		.DEPTH      (DEPTH),
		.COUNT_BITS (COUNT_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.value     (value),
		.position  (position),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata)
	);

	flol_mem #(
		.DEPTH (DEPTH),
		.WIDTH (EW)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	// output register: take a result when empty or being drained
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_q.status;
	assign entry_position = rsp_q.position;
	assign entry_value    = rsp_q.value;
	assign entry_count    = rsp_q.count;

	// a result handed over always shows up at the output
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> rsp_valid)
		else $error("result lost at output register");

endmodule

// File: dv/tb.sv
module tb;

	localparam int DEPTH = 16;
	localparam logic [flol_pkg::CNT_W-1:0] COUNT_TOP = '1;
	localparam int FRONT_LOCATES = 40;
	localparam int RANDOM_ITEMS = 1170;
	localparam int HOLD_AT_RESULT = 60;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [1:0]                   op;
		logic [flol_pkg::VALUE_W-1:0] key;
		logic [flol_pkg::POS_W-1:0]   pos;
	} table_req_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [1:0] cmd = flol_pkg::CMD_CLEAR;
	logic signed [flol_pkg::VALUE_W-1:0] value = '0;
	logic [flol_pkg::POS_W-1:0] position = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [1:0] status;
	logic [flol_pkg::POS_W-1:0] entry_position;
	logic signed [flol_pkg::VALUE_W-1:0] entry_value;
	logic [flol_pkg::CNT_W-1:0] entry_count;

	// predicted table contents
	logic [flol_pkg::VALUE_W-1:0] tbl_val [DEPTH];
	logic [flol_pkg::CNT_W-1:0]   tbl_cnt [DEPTH];
	int                           tbl_used = 0;

	table_req_t req_backlog [$];
	flol_pkg::result_t predicted_rsp [$];
	logic [flol_pkg::VALUE_W-1:0] key_pool [20];
	int bad_fields = 0;

	// sender and receiver idle state
	int tx_gap = 0;
	bit tx_calm = 1'b0;
	int rx_stall = 0;
	int rx_hold = 0;
	bit rx_calm = 1'b0;
	int results_seen = 0;

	frequency_ordered_lookup_table #(
		.DEPTH(DEPTH),
		.COUNT_BITS(flol_pkg::CNT_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.value(value),
		.position(position),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.status(status),
		.entry_position(entry_position),
		.entry_value(entry_value),
		.entry_count(entry_count)
	);

	always #2 clk = ~clk;

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// apply one transaction to the predicted table and return its result
	function automatic flol_pkg::result_t apply_to_table(logic [1:0] op,
			logic [flol_pkg::VALUE_W-1:0] key, logic [flol_pkg::POS_W-1:0] pos);
		flol_pkg::result_t r;
		int hit;
		int dest;
		int k;
		logic [flol_pkg::VALUE_W-1:0] v;
		logic [flol_pkg::CNT_W-1:0] c;
		r = '0;
		r.status = flol_pkg::STATUS_OK;
		hit = -1;
		dest = 0;
		case (op)
		flol_pkg::CMD_CLEAR: begin
			tbl_used = 0;
		end
		flol_pkg::CMD_APPEND: begin
			if (tbl_used >= DEPTH) begin
				r.status = flol_pkg::STATUS_FULL;
			end else begin
				tbl_val[tbl_used] = key;
				tbl_cnt[tbl_used] = '0;
				r.position = flol_pkg::POS_W'(tbl_used);
				r.value = key;
				tbl_used++;
			end
		end
		flol_pkg::CMD_READ: begin
			if (int'(pos) >= tbl_used) begin
				r.status = flol_pkg::STATUS_BEYOND;
			end else begin
				r.position = pos;
				r.value = tbl_val[pos];
				r.count = tbl_cnt[pos];
			end
		end
		flol_pkg::CMD_LOCATE: begin
			for (k = 0; k < tbl_used; k++) begin
				if (tbl_val[k] == key) begin
					hit = k;
					break;
				end
			end
			if (hit < 0) begin
				r.status = flol_pkg::STATUS_NOT_FOUND;
			end else begin
				v = tbl_val[hit];
				c = (tbl_cnt[hit] == COUNT_TOP) ? COUNT_TOP : tbl_cnt[hit] + 1'b1;
				// skip the other entries whose count is strictly larger
				for (k = 0; k < tbl_used; k++) begin
					if (k == hit)
						continue;
					if (tbl_cnt[k] <= c)
						break;
					dest++;
				end
				// pull the entry out and reinsert it at its new slot
				if (dest < hit) begin
					for (k = hit; k > dest; k--) begin
						tbl_val[k] = tbl_val[k-1];
						tbl_cnt[k] = tbl_cnt[k-1];
					end
				end else begin
					for (k = hit; k < dest; k++) begin
						tbl_val[k] = tbl_val[k+1];
						tbl_cnt[k] = tbl_cnt[k+1];
					end
				end
				tbl_val[dest] = v;
				tbl_cnt[dest] = c;
				r.position = flol_pkg::POS_W'(dest);
				r.value = v;
				r.count = c;
			end
		end
		default: begin
			r.status = flol_pkg::STATUS_OK;
		end
		endcase
		return r;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	function automatic logic [flol_pkg::VALUE_W-1:0] pick_key();
		if ($urandom_range(0, 99) < 85)
			return key_pool[$urandom_range(0, 19)];
		return $urandom;
	endfunction

	function automatic logic [flol_pkg::POS_W-1:0] rand_pos();
		return flol_pkg::POS_W'($urandom_range(0, 15));
	endfunction

	task automatic push_req(logic [1:0] op, logic [flol_pkg::VALUE_W-1:0] key,
			logic [flol_pkg::POS_W-1:0] pos);
		table_req_t t;
		t.op = op;
		t.key = key;
		t.pos = pos;
		req_backlog.push_back(t);
	endtask

	task automatic compare_field(string name, logic [flol_pkg::VALUE_W-1:0] want,
			logic [flol_pkg::VALUE_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			bad_fields++;
		end
	endtask

	// request driver: predict on acceptance, then hold, idle or load the next transaction
	always @(posedge clk or negedge arst_n) begin : drive_req
		table_req_t nxt;
		logic taken;
		if (!arst_n) begin
			req_valid <= 1'b0;
			cmd <= flol_pkg::CMD_CLEAR;
			value <= '0;
			position <= '0;
		end else begin
			taken = req_valid && req_ready;
			if (taken)
				predicted_rsp.push_back(apply_to_table(cmd, value, position));
			if (!req_valid || taken) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					nxt = req_backlog.pop_front();
					cmd <= nxt.op;
					value <= nxt.key;
					position <= nxt.pos;
					req_valid <= 1'b1;
					if ($urandom_range(0, 63) == 0)
						tx_calm = !tx_calm;
					tx_gap = tx_calm ? 0 : idle_len();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response monitor: check each transaction, then pick the next ready level
	always @(posedge clk or negedge arst_n) begin : watch_rsp
		flol_pkg::result_t want;
		logic took;
		logic nxt_ready;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			took = rsp_valid && rsp_ready;
			if (took) begin
				results_seen++;
				if (predicted_rsp.size() == 0) begin
					$display("%0t: unexpected result status %0h position %0h value %0h count %0h",
						$time, status, entry_position, entry_value, entry_count);
					bad_fields++;
				end else begin
					want = predicted_rsp.pop_front();
					compare_field("status", flol_pkg::VALUE_W'(want.status),
						flol_pkg::VALUE_W'(status));
					compare_field("entry_position", flol_pkg::VALUE_W'(want.position),
						flol_pkg::VALUE_W'(entry_position));
					compare_field("entry_value", want.value, entry_value);
					compare_field("entry_count", flol_pkg::VALUE_W'(want.count),
						flol_pkg::VALUE_W'(entry_count));
				end
				// back off for a long stretch once, so the block fills and stalls its input
				if (results_seen == HOLD_AT_RESULT)
					rx_hold = HOLD_CYCLES;
				if ($urandom_range(0, 63) == 0)
					rx_calm = !rx_calm;
			end
			if (rx_hold > 0) begin
				rx_hold--;
				nxt_ready = 1'b0;
			end else if (rx_stall > 0) begin
				rx_stall--;
				nxt_ready = 1'b0;
			end else begin
				if (!rx_calm && $urandom_range(0, 7) == 0)
					rx_stall = idle_len();
				nxt_ready = (rx_stall == 0);
			end
			rsp_ready <= nxt_ready;
		end
	end

	// build the stimulus, then wait for the last result
	initial begin
		logic [flol_pkg::VALUE_W-1:0] hot_key;
		int r;
		for (int i = 0; i < 20; i++)
			key_pool[i] = (i < 10) ? $urandom :
				flol_pkg::VALUE_W'($urandom_range(0, 15) - 8);

		// empty table: miss and read beyond the count
		push_req(flol_pkg::CMD_LOCATE, 32'h0000_0000, rand_pos());
		push_req(flol_pkg::CMD_READ, $urandom, 4'd0);
		// extremes of the value field
		push_req(flol_pkg::CMD_APPEND, 32'h7FFF_FFFF, rand_pos());
		push_req(flol_pkg::CMD_APPEND, 32'h8000_0000, rand_pos());
		push_req(flol_pkg::CMD_APPEND, 32'h0000_0000, rand_pos());
		push_req(flol_pkg::CMD_APPEND, 32'hFFFF_FFFF, rand_pos());
		// move from the tail to the front, then ahead of an equal count
		push_req(flol_pkg::CMD_LOCATE, 32'hFFFF_FFFF, rand_pos());
		push_req(flol_pkg::CMD_LOCATE, 32'hFFFF_FFFF, rand_pos());
		push_req(flol_pkg::CMD_LOCATE, 32'h0000_0000, rand_pos());
		push_req(flol_pkg::CMD_LOCATE, 32'h7FFF_FFFF, rand_pos());
		push_req(flol_pkg::CMD_LOCATE, 32'h0000_3039, rand_pos());
		push_req(flol_pkg::CMD_READ, $urandom, 4'd1);
		push_req(flol_pkg::CMD_READ, $urandom, 4'd4);
		// fill with a duplicate in it, then overflow
		for (int i = 0; i < 11; i++)
			push_req(flol_pkg::CMD_APPEND, $urandom, rand_pos());
		push_req(flol_pkg::CMD_APPEND, 32'h0000_0000, rand_pos());
		push_req(flol_pkg::CMD_APPEND, $urandom, rand_pos());
		push_req(flol_pkg::CMD_LOCATE, 32'h0000_0000, rand_pos());
		push_req(flol_pkg::CMD_READ, $urandom, 4'd15);
		push_req(flol_pkg::CMD_CLEAR, $urandom, rand_pos());
		push_req(flol_pkg::CMD_READ, $urandom, 4'd0);

		// keep locating one entry so its count climbs well past the others
		hot_key = $urandom;
		push_req(flol_pkg::CMD_APPEND, ~hot_key, rand_pos());
		push_req(flol_pkg::CMD_APPEND, hot_key, rand_pos());
		push_req(flol_pkg::CMD_LOCATE, ~hot_key, rand_pos());
		repeat (FRONT_LOCATES)
			push_req(flol_pkg::CMD_LOCATE, hot_key, rand_pos());
		push_req(flol_pkg::CMD_LOCATE, ~hot_key, rand_pos());
		push_req(flol_pkg::CMD_READ, $urandom, 4'd0);
		push_req(flol_pkg::CMD_READ, $urandom, 4'd1);
		push_req(flol_pkg::CMD_CLEAR, $urandom, rand_pos());

		// random mix weighted toward appends and locates on pooled keys
		repeat (RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 3)
				push_req(flol_pkg::CMD_CLEAR, $urandom, rand_pos());
			else if (r < 33)
				push_req(flol_pkg::CMD_APPEND, pick_key(), rand_pos());
			else if (r < 78)
				push_req(flol_pkg::CMD_LOCATE, pick_key(), rand_pos());
			else
				push_req(flol_pkg::CMD_READ, $urandom, rand_pos());
		end

		while (req_backlog.size() != 0 || req_valid || predicted_rsp.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (bad_fields == 0)
			$display("frequency_ordered_lookup_table: match");
		else
			$display("frequency_ordered_lookup_table: mismatch");
		$finish;
	end

	// stop a hung run
	initial begin
		#100000000;
		$display("frequency_ordered_lookup_table: mismatch");
		$finish;
	end

endmodule
